FILE: src/i2cms_pkg.sv
// shared types and constants for the i2c master bit sequencer
package i2cms_pkg;

    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] RECOVERY_LIMIT_RST = 4'd10;
    localparam logic [3:0] ACK_GROUP = 4'd8;

    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_SEND_ADDR = 3'd1,
        OP_SEND_DATA = 3'd2,
        OP_RECEIVE   = 3'd3,
        OP_STOP      = 3'd4,
        OP_RECOVER   = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        STS_OK            = 3'd0,
        STS_NACK          = 3'd1,
        STS_START_FAIL    = 3'd2,
        STS_REFUSED       = 3'd3,
        STS_RECOVERY_BUSY = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACTIVE = 2'd1,
        PH_FAILED = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        PS_HOLD_PINS,
        PS_RELEASE_SDA,
        PS_HOLD_SDA,
        PS_BIT_LOW,
        PS_BIT_HIGH,
        PS_LOW_ONE,
        PS_LOW_ZERO,
        PS_HIGH_ZERO,
        PS_HIGH_ONE,
        PS_SAMPLE
    } t_pin_step;

    typedef enum logic {
        CS_IDLE,
        CS_RUN
    } t_ctrl_state;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  data_byte;
        logic        read_not_write;
        logic        last_byte;
        logic [7:0]  slave_bits;
        logic        ack_sample;
        logic        start_sample;
        logic [14:0] recover_samples;
    } t_cmd_word;

    typedef struct packed {
        logic      load;
        logic      emit;
        t_pin_step step;
        logic      last;
    } t_dp_ctrl;

    typedef struct packed {
        logic [2:0] opcode;
        logic       refused;
        logic       start_ok;
        logic       last_byte;
        logic       rec_hit;
        logic [3:0] lim_m1;
        logic       out_free;
    } t_dp_status;

endpackage

FILE: src/i2cms_cmd_if.sv
// command channel interface
interface i2cms_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [7:0]  data_byte;
    logic        read_not_write;
    logic        last_byte;
    logic [7:0]  slave_bits;
    logic        ack_sample;
    logic        start_sample;
    logic [14:0] recover_samples;

    modport source (
        output valid, opcode, data_byte, read_not_write, last_byte, slave_bits,
               ack_sample, start_sample, recover_samples,
        input  ready
    );
    modport sink (
        input  valid, opcode, data_byte, read_not_write, last_byte, slave_bits,
               ack_sample, start_sample, recover_samples,
        output ready
    );
endinterface

FILE: src/i2cms_pin_if.sv
// pin state channel interface
interface i2cms_pin_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sample_point;
    logic       last_state;
    logic [2:0] status;
    logic [7:0] read_data;

    modport source (
        output valid, scl_level, sda_level, sample_point, last_state, status, read_data,
        input  ready
    );
    modport sink (
        input  valid, scl_level, sda_level, sample_point, last_state, status, read_data,
        output ready
    );
endinterface

FILE: src/i2cms_ctrl.sv
// command sequencer state machine choosing the pin step of each word
module i2cms_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  i2cms_pkg::t_dp_status  i_stat,
    output i2cms_pkg::t_dp_ctrl    o_ctrl
);

    i2cms_pkg::t_ctrl_state r_state, n_state;
    logic [3:0] r_grp, n_grp;
    logic [2:0] r_sub, n_sub;

    i2cms_pkg::t_pin_step step;
    logic step_last;
    logic grp_end;
    logic known;
    logic ack_grp;

    assign ack_grp = (r_grp == i2cms_pkg::ACK_GROUP);

    always_comb begin
        step      = i2cms_pkg::PS_HOLD_PINS;
        step_last = 1'b0;
        grp_end   = 1'b0;
        known     = 1'b1;
        if (i_stat.refused) begin
            step_last = 1'b1;
        end else begin
            unique case (i2cms_pkg::t_opcode'(i_stat.opcode))
                i2cms_pkg::OP_START: begin
                    unique case (r_sub)
                        3'd0: step = i2cms_pkg::PS_RELEASE_SDA;
                        3'd1: begin
                            step      = i2cms_pkg::PS_SAMPLE;
                            step_last = !i_stat.start_ok;
                        end
                        default: begin
                            step      = i2cms_pkg::PS_HIGH_ZERO;
                            step_last = 1'b1;
                        end
                    endcase
                end
                i2cms_pkg::OP_SEND_ADDR, i2cms_pkg::OP_SEND_DATA: begin
                    unique case (r_sub)
                        3'd0: step = i2cms_pkg::PS_HOLD_SDA;
                        3'd1: step = ack_grp ? i2cms_pkg::PS_LOW_ONE : i2cms_pkg::PS_BIT_LOW;
                        default: begin
                            step      = ack_grp ? i2cms_pkg::PS_SAMPLE : i2cms_pkg::PS_BIT_HIGH;
                            step_last = ack_grp;
                            grp_end   = 1'b1;
                        end
                    endcase
                end
                i2cms_pkg::OP_RECEIVE: begin
                    if (!ack_grp) begin
                        if (r_sub == 3'd0) begin
                            step = i2cms_pkg::PS_LOW_ONE;
                        end else begin
                            step    = i2cms_pkg::PS_SAMPLE;
                            grp_end = 1'b1;
                        end
                    end else if (i_stat.last_byte) begin
                        unique case (r_sub)
                            3'd0, 3'd1: step = i2cms_pkg::PS_LOW_ONE;
                            default: begin
                                step      = i2cms_pkg::PS_HIGH_ONE;
                                step_last = 1'b1;
                            end
                        endcase
                    end else begin
                        unique case (r_sub)
                            3'd0: step = i2cms_pkg::PS_LOW_ONE;
                            3'd1: step = i2cms_pkg::PS_LOW_ZERO;
                            3'd2: step = i2cms_pkg::PS_HIGH_ZERO;
                            3'd3: step = i2cms_pkg::PS_LOW_ZERO;
                            default: begin
                                step      = i2cms_pkg::PS_LOW_ONE;
                                step_last = 1'b1;
                            end
                        endcase
                    end
                end
                i2cms_pkg::OP_STOP: begin
                    unique case (r_sub)
                        3'd0: step = i2cms_pkg::PS_HOLD_SDA;
                        3'd1: step = i2cms_pkg::PS_LOW_ZERO;
                        3'd2: step = i2cms_pkg::PS_HIGH_ZERO;
                        3'd3: step = i2cms_pkg::PS_HIGH_ONE;
                        default: begin
                            step      = i2cms_pkg::PS_HIGH_ONE;
                            step_last = 1'b1;
                        end
                    endcase
                end
                i2cms_pkg::OP_RECOVER: begin
                    if (r_sub == 3'd0) begin
                        step = i2cms_pkg::PS_LOW_ONE;
                    end else begin
                        step      = i2cms_pkg::PS_SAMPLE;
                        grp_end   = 1'b1;
                        step_last = i_stat.rec_hit || (r_grp == i_stat.lim_m1);
                    end
                end
                default: known = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2cms_pkg::CS_IDLE;
            r_grp   <= 4'd0;
            r_sub   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_grp   <= n_grp;
            r_sub   <= n_sub;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_grp       = r_grp;
        n_sub       = r_sub;
        o_ready     = 1'b0;
        o_ctrl.load = 1'b0;
        o_ctrl.emit = 1'b0;
        o_ctrl.step = step;
        o_ctrl.last = step_last;
        unique case (r_state)
            i2cms_pkg::CS_IDLE: begin
                o_ready     = 1'b1;
                o_ctrl.load = i_valid;
                if (i_valid) begin
                    n_state = i2cms_pkg::CS_RUN;
                    n_grp   = 4'd0;
                    n_sub   = 3'd0;
                end
            end
            i2cms_pkg::CS_RUN: begin
                if (!known) begin
                    n_state = i2cms_pkg::CS_IDLE;
                end else if (i_stat.out_free) begin
                    o_ctrl.emit = 1'b1;
                    if (step_last) begin
                        n_state = i2cms_pkg::CS_IDLE;
                    end else if (grp_end) begin
                        n_sub = 3'd0;
                        n_grp = r_grp + 4'd1;
                    end else begin
                        n_sub = r_sub + 3'd1;
                    end
                end
            end
            default: n_state = i2cms_pkg::CS_IDLE;
        endcase
    end

endmodule

FILE: src/i2cms_dp.sv
// datapath: command registers, pin and phase state, output word register
module i2cms_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [3:0]             i_cfg_wdata,
    input  i2cms_pkg::t_cmd_word   i_cmd_word,
    input  i2cms_pkg::t_dp_ctrl    i_ctrl,
    output i2cms_pkg::t_dp_status  o_stat,
    i2cms_pin_if.source            o_pin
);

    logic [3:0]        r_cfg;
    i2cms_pkg::t_phase r_phase, n_phase;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic [2:0]        r_op;
    logic [7:0]        r_shift;
    logic              r_last_byte;
    logic [7:0]        r_sbits;
    logic              r_ack;
    logic              r_ssmp;
    logic [14:0]       r_rsmp;
    logic              r_refused;

    logic              r_vld;
    logic              r_o_scl;
    logic              r_o_sda;
    logic              r_o_smp;
    logic              r_o_last;
    logic [2:0]        r_o_status;
    logic [7:0]        r_o_data;

    logic              smp;
    i2cms_pkg::t_status status;
    logic [7:0]        rdata;

    assign o_stat.opcode    = r_op;
    assign o_stat.refused   = r_refused;
    assign o_stat.start_ok  = r_ssmp;
    assign o_stat.last_byte = r_last_byte;
    assign o_stat.rec_hit   = r_rsmp[0];
    assign o_stat.lim_m1    = (r_cfg == 4'd0) ? 4'd0 : r_cfg - 4'd1;
    assign o_stat.out_free  = !r_vld || o_pin.ready;

    always_comb begin
        n_scl = r_scl;
        n_sda = r_sda;
        smp   = 1'b0;
        unique case (i_ctrl.step)
            i2cms_pkg::PS_HOLD_PINS:   ;
            i2cms_pkg::PS_RELEASE_SDA: n_sda = 1'b1;
            i2cms_pkg::PS_HOLD_SDA:    n_scl = 1'b0;
            i2cms_pkg::PS_BIT_LOW: begin
                n_scl = 1'b0;
                n_sda = r_shift[7];
            end
            i2cms_pkg::PS_BIT_HIGH: begin
                n_scl = 1'b1;
                n_sda = r_shift[7];
            end
            i2cms_pkg::PS_LOW_ONE: begin
                n_scl = 1'b0;
                n_sda = 1'b1;
            end
            i2cms_pkg::PS_LOW_ZERO: begin
                n_scl = 1'b0;
                n_sda = 1'b0;
            end
            i2cms_pkg::PS_HIGH_ZERO: begin
                n_scl = 1'b1;
                n_sda = 1'b0;
            end
            i2cms_pkg::PS_HIGH_ONE: begin
                n_scl = 1'b1;
                n_sda = 1'b1;
            end
            i2cms_pkg::PS_SAMPLE: begin
                n_scl = 1'b1;
                n_sda = 1'b1;
                smp   = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        status  = i2cms_pkg::STS_OK;
        rdata   = 8'd0;
        n_phase = r_phase;
        if (r_refused) begin
            status = i2cms_pkg::STS_REFUSED;
        end else begin
            unique case (i2cms_pkg::t_opcode'(r_op))
                i2cms_pkg::OP_START: begin
                    status  = r_ssmp ? i2cms_pkg::STS_OK : i2cms_pkg::STS_START_FAIL;
                    n_phase = r_ssmp ? i2cms_pkg::PH_ACTIVE : i2cms_pkg::PH_FAILED;
                end
                i2cms_pkg::OP_SEND_ADDR, i2cms_pkg::OP_SEND_DATA: begin
                    status  = r_ack ? i2cms_pkg::STS_NACK : i2cms_pkg::STS_OK;
                    n_phase = r_ack ? i2cms_pkg::PH_FAILED : i2cms_pkg::PH_ACTIVE;
                end
                i2cms_pkg::OP_RECEIVE: begin
                    rdata   = r_sbits;
                    n_phase = i2cms_pkg::PH_ACTIVE;
                end
                i2cms_pkg::OP_STOP: begin
                    if (r_phase != i2cms_pkg::PH_FAILED) begin
                        n_phase = i2cms_pkg::PH_IDLE;
                    end
                end
                i2cms_pkg::OP_RECOVER: begin
                    status  = r_rsmp[0] ? i2cms_pkg::STS_OK : i2cms_pkg::STS_RECOVERY_BUSY;
                    n_phase = r_rsmp[0] ? i2cms_pkg::PH_IDLE : i2cms_pkg::PH_FAILED;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= i2cms_pkg::RECOVERY_LIMIT_RST;
            r_phase <= i2cms_pkg::PH_IDLE;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_ctrl.emit) begin
                r_scl <= n_scl;
                r_sda <= n_sda;
                r_vld <= 1'b1;
                if (i_ctrl.last) begin
                    r_phase <= n_phase;
                end
            end else if (o_pin.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_op        <= i_cmd_word.opcode;
            r_shift     <= (i2cms_pkg::t_opcode'(i_cmd_word.opcode) == i2cms_pkg::OP_SEND_ADDR)
                         ? {i_cmd_word.data_byte[7:1], i_cmd_word.read_not_write}
                         : i_cmd_word.data_byte;
            r_last_byte <= i_cmd_word.last_byte;
            r_sbits     <= i_cmd_word.slave_bits;
            r_ack       <= i_cmd_word.ack_sample;
            r_ssmp      <= i_cmd_word.start_sample;
            r_rsmp      <= i_cmd_word.recover_samples;
            r_refused   <= (r_phase == i2cms_pkg::PH_FAILED)
                         && (i_cmd_word.opcode <= 3'(i2cms_pkg::OP_RECEIVE));
        end else if (i_ctrl.emit) begin
            if (i_ctrl.step == i2cms_pkg::PS_BIT_HIGH) begin
                r_shift <= {r_shift[6:0], 1'b0};
            end
            if (i_ctrl.step == i2cms_pkg::PS_SAMPLE) begin
                r_rsmp <= {1'b0, r_rsmp[14:1]};
            end
        end
        if (i_ctrl.emit) begin
            r_o_scl    <= n_scl;
            r_o_sda    <= n_sda;
            r_o_smp    <= smp;
            r_o_last   <= i_ctrl.last;
            r_o_status <= i_ctrl.last ? status : i2cms_pkg::STS_OK;
            r_o_data   <= i_ctrl.last ? rdata : 8'd0;
        end
    end

    assign o_pin.valid        = r_vld;
    assign o_pin.scl_level    = r_o_scl;
    assign o_pin.sda_level    = r_o_sda;
    assign o_pin.sample_point = r_o_smp;
    assign o_pin.last_state   = r_o_last;
    assign o_pin.status       = r_o_status;
    assign o_pin.read_data    = r_o_data;

endmodule

FILE: src/i2c_master_bit_sequencer.sv
// top level of the i2c master bit sequencer
// usage:
//   i_cmd takes one bus command word: start, send address, send data, receive,
//   stop or recover, with the slave's sda samples carried alongside
//   o_pin gives one word per scl/sda pin state, last_state marks the final one
//   and status / read_data are meaningful only there
//   i_cfg_we / i_cfg_wdata set the recovery pulse limit (reset 10, 0 acts as 1)
// timing:
//   a command is taken while the sequencer is idle, then its pin states leave one
//   per cycle from the output register unless the receiver stalls: 3 for start
//   or 2 when it fails, 27 for a send, 19 or 21 for receive, 5 for stop, 2 per
//   recovery pulse, 1 for a refused command
//   the next command is taken once the last pin state of the current one is loaded
//   an unused opcode gives no pin state and the sequencer returns to idle
// reset leaves both lines released, the bus idle and the pulse limit at 10
// a stalled receiver holds the output word and the sequencer waits on it
module i2c_master_bit_sequencer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [3:0]   i_cfg_wdata,
    i2cms_cmd_if.sink    i_cmd,
    i2cms_pin_if.source  o_pin
);

    i2cms_pkg::t_cmd_word  cmd_word;
    i2cms_pkg::t_dp_ctrl   dp_ctrl;
    i2cms_pkg::t_dp_status dp_stat;
    logic                  cmd_ready;

    assign cmd_word.opcode          = i_cmd.opcode;
    assign cmd_word.data_byte       = i_cmd.data_byte;
    assign cmd_word.read_not_write  = i_cmd.read_not_write;
    assign cmd_word.last_byte       = i_cmd.last_byte;
    assign cmd_word.slave_bits      = i_cmd.slave_bits;
    assign cmd_word.ack_sample      = i_cmd.ack_sample;
    assign cmd_word.start_sample    = i_cmd.start_sample;
    assign cmd_word.recover_samples = i_cmd.recover_samples;
    assign i_cmd.ready              = cmd_ready;

    i2cms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .o_ready (cmd_ready),
        .i_stat  (dp_stat),
        .o_ctrl  (dp_ctrl)
    );

    i2cms_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_word  (cmd_word),
        .i_ctrl      (dp_ctrl),
        .o_stat      (dp_stat),
        .o_pin       (o_pin)
    );

`ifndef NO_ASSERTIONS
    a_one_cmd_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while another is in progress");

    a_status_on_last_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pin.valid && !o_pin.last_state |-> o_pin.status == 3'(i2cms_pkg::STS_OK)
            && o_pin.read_data == 8'd0)
        else $error("status or read data on a non-final pin state");

    a_sample_with_scl_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pin.valid && o_pin.sample_point |-> o_pin.scl_level && o_pin.sda_level)
        else $error("sample point without scl high and sda released");

    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_ctrl.emit |-> !o_pin.valid || o_pin.ready)
        else $error("pin state loaded over an untaken word");
`endif

endmodule
